/* hw/rtl/pss_pkg.sv */
// ----------------------------------------------------------------------------
// pss_pkg
// shared types and constants of the plucked-string voice
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int unsigned MaxPeriodDefault = 2048;

  localparam int unsigned ActionW = 2;
  localparam int unsigned PeriodW = 12;
  localparam int unsigned SampleW = 16;

  typedef enum logic [ActionW-1:0] {
    ActStart = 2'd0,
    ActLoad  = 2'd1,
    ActTick  = 2'd2
  } action_e;

endpackage

/* hw/rtl/pss_ram.sv */
// ----------------------------------------------------------------------------
// pss_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module pss_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2048,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read sees the old word when the same entry is written in the same cycle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/plucked_string_synth.sv */
// ----------------------------------------------------------------------------
// plucked_string_synth
// karplus-strong plucked-string voice: delay line in one ram, averaging loop
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid_i, in_ready_o, action_i,         | in
//          | period_i, noise_value_i                   |
//  result  | out_valid_o, out_ready_i, sample_o        | out
//
// one request per cycle is taken while the second stage is empty or can
// advance; for a tick the accepting edge latches the delay-line ram read, and
// the output register is loaded when the tick leaves the second stage.
// the rate is set by the single ram port pair: each request does at most one
// read at issue and one write when it leaves the second stage.
// reset clears pointers, period (to one), previous output and valid flags;
// the delay line itself is not cleared and needs no clearing pass.
// a stalled output register holds a tick in the second stage, which in turn
// holds in_ready_o low; nothing is lost or repeated under back-pressure.
//
module plucked_string_synth
  import pss_pkg::*;
#(
  parameter int unsigned MaxPeriod = MaxPeriodDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ActionW-1:0]        action_i,
  input  logic [PeriodW-1:0]        period_i,
  input  logic signed [SampleW-1:0] noise_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] sample_o
);

  localparam int unsigned AddrW = $clog2(MaxPeriod);

  // halve a sample, rounding toward zero
  function automatic logic signed [SampleW-1:0] half_tz(input logic signed [SampleW-1:0] x);
    logic signed [SampleW:0] t;
    t = {x[SampleW-1], x} + {{SampleW{1'b0}}, x[SampleW-1]};
    return t[SampleW:1];
  endfunction

  // advance a pointer modulo the current period
  function automatic logic [AddrW-1:0] next_ptr(input logic [AddrW-1:0] p,
                                                input logic [PeriodW-1:0] per);
    logic [31:0] n;
    n = 32'(p) + 32'd1;
    return (n >= 32'(per)) ? '0 : n[AddrW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // issue stage: pointer and period state, ram read
  // --------------------------------------------------------------------------
  logic               accept;
  action_e            act;
  logic               act_known;
  logic [PeriodW-1:0] period_clamped;

  logic [PeriodW-1:0] note_period_q, note_period_d;
  logic [AddrW-1:0]   read_ptr_q, read_ptr_d;
  logic [AddrW-1:0]   fill_ptr_q, fill_ptr_d;

  assign accept = in_valid_i && in_ready_o;
  assign act    = action_e'(action_i);

  always_comb begin
    case (act)
      ActStart, ActLoad, ActTick: act_known = 1'b1;
      default:                    act_known = 1'b0;
    endcase
  end

  // zero period counts as one, long periods saturate at the line length
  always_comb begin
    period_clamped = period_i;
    if (period_i == '0) begin
      period_clamped = PeriodW'(1);
    end else if (32'(period_i) > 32'(MaxPeriod)) begin
      period_clamped = PeriodW'(MaxPeriod);
    end
  end

  always_comb begin
    note_period_d = note_period_q;
    read_ptr_d    = read_ptr_q;
    fill_ptr_d    = fill_ptr_q;
    if (accept) begin
      case (act)
        ActStart: begin
          note_period_d = period_clamped;
          read_ptr_d    = '0;
          fill_ptr_d    = '0;
        end
        ActLoad:  fill_ptr_d = next_ptr(fill_ptr_q, note_period_q);
        ActTick:  read_ptr_d = next_ptr(read_ptr_q, note_period_q);
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_period_q <= PeriodW'(1);
      read_ptr_q    <= '0;
      fill_ptr_q    <= '0;
    end else begin
      note_period_q <= note_period_d;
      read_ptr_q    <= read_ptr_d;
      fill_ptr_q    <= fill_ptr_d;
    end
  end

  // --------------------------------------------------------------------------
  // second stage: combine, write back, hand over to the output register
  // --------------------------------------------------------------------------
  logic                      s1_valid_q, s1_valid_d;
  action_e                   s1_act_q;
  logic [AddrW-1:0]          s1_addr_q;
  logic signed [SampleW-1:0] s1_noise_q;
  logic                      fwd_q;
  logic signed [SampleW-1:0] fwd_data_q;
  logic signed [SampleW-1:0] prev_q, prev_d;

  logic                      s1_adv;
  logic                      s1_is_tick;
  logic                      ram_we;
  logic signed [SampleW-1:0] ram_wdata;
  logic [SampleW-1:0]        ram_rdata;
  logic signed [SampleW-1:0] cur;
  logic signed [SampleW-1:0] sum;
  logic [AddrW-1:0]          issue_addr;
  logic                      fwd_hit;

  logic                      out_valid_q, out_valid_d;
  logic signed [SampleW-1:0] sample_q;

  assign s1_is_tick = s1_valid_q && (s1_act_q == ActTick);
  // a tick may only leave when the output register has room
  assign s1_adv     = !s1_is_tick || !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;

  // the ram read misses a write to its entry that leaves stage two as it issues
  assign cur = fwd_q ? fwd_data_q : $signed(ram_rdata);
  assign sum = half_tz(cur) + half_tz(prev_q);

  assign ram_we    = s1_valid_q && s1_adv && (s1_act_q == ActLoad || s1_act_q == ActTick);
  assign ram_wdata = (s1_act_q == ActTick) ? sum : s1_noise_q;

  assign issue_addr = (act == ActLoad) ? fill_ptr_q : read_ptr_q;
  assign fwd_hit    = ram_we && (s1_addr_q == read_ptr_q);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = act_known;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    prev_d = prev_q;
    if (s1_valid_q && s1_adv) begin
      case (s1_act_q)
        ActStart: prev_d = '0;
        ActTick:  prev_d = sum;
        default:  ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_is_tick && s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_act_q   <= act;
      s1_addr_q  <= issue_addr;
      s1_noise_q <= noise_value_i;
      fwd_q      <= fwd_hit;
      fwd_data_q <= ram_wdata;
    end
    if (s1_is_tick && s1_adv) begin
      sample_q <= sum;
    end
  end

  pss_ram #(
    .Width (SampleW),
    .Depth (MaxPeriod)
  ) u_delay_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (ram_wdata),
    .re_i    (accept && (act == ActTick)),
    .raddr_i (read_ptr_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

endmodule

/* tb/pss_checker.sv */
// ----------------------------------------------------------------------------
// pss_checker
// watches both channels of the plucked-string voice, keeps its own copy of
// the delay line and pointers, and compares each sample with the oldest one
// predicted
// ----------------------------------------------------------------------------
module pss_checker
  import pss_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [ActionW-1:0]        action_i,
  input  logic [PeriodW-1:0]        period_i,
  input  logic signed [SampleW-1:0] noise_value_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [SampleW-1:0] sample_i,
  output int                        fail_count_o,
  output int                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // predictor state
  logic signed [SampleW-1:0] line_mem [MaxPeriodDefault];
  int                        note_len;
  int                        rd_idx;
  int                        fill_idx;
  logic signed [SampleW-1:0] last_sample;

  // samples predicted but not yet seen
  logic signed [SampleW-1:0] sample_q [$];

  function automatic int wrap_next(input int p);
    return (p + 1 >= note_len) ? 0 : p + 1;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    note_len     = 1;
    rd_idx       = 0;
    fill_idx     = 0;
    last_sample  = '0;
    foreach (line_mem[i]) line_mem[i] = '0;
  end

  always @(posedge clk_i) begin : predict_and_compare
    int                        len;
    int                        cur;
    int                        prev;
    int                        sum;
    logic signed [SampleW-1:0] got_exp;
    if (!rst_ni) begin
      note_len    = 1;
      rd_idx      = 0;
      fill_idx    = 0;
      last_sample = '0;
    end else begin
      // accepted request
      if (in_valid_i && in_ready_i) begin
        case (action_i)
          ActStart: begin
            len = period_i;
            if (len == 0) len = 1;
            if (len > MaxPeriodDefault) len = MaxPeriodDefault;
            note_len    = len;
            rd_idx      = 0;
            fill_idx    = 0;
            last_sample = '0;
          end
          ActLoad: begin
            line_mem[fill_idx] = noise_value_i;
            fill_idx           = wrap_next(fill_idx);
          end
          ActTick: begin
            // both halves truncate toward zero
            cur  = line_mem[rd_idx];
            prev = last_sample;
            sum  = cur / 2 + prev / 2;
            line_mem[rd_idx] = sum[SampleW-1:0];
            last_sample      = sum[SampleW-1:0];
            rd_idx           = wrap_next(rd_idx);
            sample_q.push_back(sum[SampleW-1:0]);
          end
          default: begin
          end
        endcase
      end
      // accepted result
      if (out_valid_i && out_ready_i) begin
        if (sample_q.size() == 0) begin
          $display("%0t: sample expected none actual %0d", $time, sample_i);
          fail_count_o++;
        end else begin
          got_exp = sample_q.pop_front();
          if (sample_i !== got_exp) begin
            $display("%0t: sample expected %0d actual %0d", $time, got_exp, sample_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = sample_q.size();
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the plucked-string voice: directed notes covering
// period limits, wraps and sample extremes, then random notes under several
// idle and back-pressure phases; checking is done by pss_checker
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pss_pkg::*;

  localparam int unsigned NumItems    = 1500;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 16;

  // action 3 is ignored by the voice
  localparam logic [ActionW-1:0] ActIgnored = 2'd3;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [ActionW-1:0]        action_i;
  logic [PeriodW-1:0]        period_i;
  logic signed [SampleW-1:0] noise_value_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [SampleW-1:0] sample_o;

  int fail_count;
  int pending;

  // idle and stall odds in percent, changed per phase
  int idle_pct;
  int stall_pct;

  // requests that do something (ignored actions are not counted)
  int req_count;
  int cycle_cnt;

  // pointer tracking so that no tick reads an entry never loaded
  int trk_period;
  int trk_rd;
  int trk_fill;
  bit written [MaxPeriodDefault];

  plucked_string_synth i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .period_i      (period_i),
    .noise_value_i (noise_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_o      (sample_o)
  );

  pss_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .action_i      (action_i),
    .period_i      (period_i),
    .noise_value_i (noise_value_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_i      (sample_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // clock, 4 ns period
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // runaway guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("plucked_string_synth: mismatch");
      $finish;
    end
  end

  // receiver back-pressure, changed at the falling edge
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic int step_ptr(input int p);
    return (p + 1 >= trk_period) ? 0 : p + 1;
  endfunction

  // noise word biased toward the extremes
  function automatic logic [SampleW-1:0] rand_noise();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3:       return 16'h0000;
      default: return SampleW'($urandom);
    endcase
  endfunction

  // one request: optional idle cycles, then hold valid until accepted
  task automatic send_req(input logic [ActionW-1:0] act, input logic [PeriodW-1:0] per,
                          input logic [SampleW-1:0] noise);
    int len;
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    action_i      <= act;
    period_i      <= per;
    noise_value_i <= noise;
    do @(posedge clk_i); while (!in_ready_o);
    // mirror the pointers for tick legality
    case (act)
      ActStart: begin
        len = per;
        if (len == 0) len = 1;
        if (len > MaxPeriodDefault) len = MaxPeriodDefault;
        trk_period = len;
        trk_rd     = 0;
        trk_fill   = 0;
      end
      ActLoad: begin
        written[trk_fill] = 1'b1;
        trk_fill = step_ptr(trk_fill);
      end
      ActTick: trk_rd = step_ptr(trk_rd);
      default: begin
      end
    endcase
    if (act != ActIgnored) req_count++;
  endtask

  // tick if the entry under the read pointer holds data, else load one more
  task automatic tick_or_load();
    if (written[trk_rd]) send_req(ActTick, PeriodW'($urandom), SampleW'($urandom));
    else send_req(ActLoad, PeriodW'($urandom), rand_noise());
  endtask

  // drop valid and wait until every predicted sample has come out
  task automatic rest_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int per;
    int nload;
    int ntick;
    int phase;
    bit paused;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = ActStart;
    period_i      = '0;
    noise_value_i = '0;
    out_ready_i   = 1'b1;
    idle_pct      = 0;
    stall_pct     = 0;
    req_count     = 0;
    cycle_cnt     = 0;
    trk_period    = 1;
    trk_rd        = 0;
    trk_fill      = 0;
    paused        = 1'b0;
    foreach (written[i]) written[i] = 1'b0;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: period zero taken as one, single-entry loop
    send_req(ActStart, 12'd0, 16'h1234);
    send_req(ActLoad, 12'hfff, 16'h7fff);
    send_req(ActTick, 12'h000, 16'h0000);
    send_req(ActTick, 12'hfff, 16'hffff);
    // three-entry line with negative extremes, load past the period wraps
    send_req(ActStart, 12'd3, 16'h0000);
    send_req(ActLoad, 12'd0, 16'h8000);
    send_req(ActLoad, 12'd0, 16'hffff);
    send_req(ActLoad, 12'd0, 16'h0001);
    send_req(ActLoad, 12'd0, 16'h8000);
    repeat (4) send_req(ActTick, 12'd0, 16'h0000);
    // ignored action changes nothing
    send_req(ActIgnored, 12'hfff, 16'hffff);
    send_req(ActTick, 12'd0, 16'h0000);
    // period above the maximum saturates, old contents are kept
    send_req(ActStart, 12'hfff, 16'h0000);
    send_req(ActLoad, 12'd0, 16'h7fff);
    send_req(ActLoad, 12'd0, 16'h7fff);
    repeat (3) send_req(ActTick, 12'd0, 16'h0000);
    send_req(ActStart, 12'd2048, 16'h0000);
    send_req(ActTick, 12'd0, 16'h0000);

    // pause with the pipeline fully drained
    rest_until_drained();

    // random notes: mostly well-formed, some broken or noisy
    while (req_count < NumItems) begin
      if (!paused && req_count > NumItems / 2) begin
        rest_until_drained();
        paused = 1'b1;
      end
      phase = req_count * 4 / NumItems;
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 88; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      // small periods most of the time, large ones rarely
      case ($urandom_range(0, 19))
        0:       per = 0;
        1:       per = $urandom_range(2049, 4095);
        2:       per = $urandom_range(1900, 2048);
        3, 4:    per = $urandom_range(17, 300);
        default: per = $urandom_range(1, 16);
      endcase
      send_req(ActStart, PeriodW'(per), SampleW'($urandom));
      nload = (per != 0 && per <= 64) ? per : $urandom_range(1, 40);
      // broken note: partial fill
      if ($urandom_range(0, 9) == 0) nload = $urandom_range(0, nload);
      // overfill to exercise the fill wrap
      if ($urandom_range(0, 7) == 0) nload += $urandom_range(1, 4);
      repeat (nload) send_req(ActLoad, PeriodW'($urandom), rand_noise());
      ntick = $urandom_range(1, 48);
      repeat (ntick) begin
        case ($urandom_range(0, 19))
          0:       send_req(ActIgnored, PeriodW'($urandom), SampleW'($urandom));
          1:       send_req(ActLoad, PeriodW'($urandom), rand_noise());
          default: tick_or_load();
        endcase
      end
    end

    // drain and let the pipeline settle
    rest_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("plucked_string_synth: match");
    end else begin
      $display("plucked_string_synth: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/pss_pkg.sv
hw/rtl/pss_ram.sv
hw/rtl/plucked_string_synth.sv
tb/pss_checker.sv
tb/testbench.sv
